>>> sv/ldsl_pkg.sv
`default_nettype none

package ldsl_pkg;

  // panel geometry
  localparam int CHAIN_LENGTH  = 44;
  localparam int SCAN_LINES    = 11;
  localparam int PANEL_SIZE    = 88;
  localparam int ROWS_PER_LINE = CHAIN_LENGTH / SCAN_LINES;
  localparam int COL_STEP      = PANEL_SIZE / SCAN_LINES;
  localparam int HALF_ROWS     = PANEL_SIZE / 2;

  // derived widths
  localparam int POS_W   = $clog2(CHAIN_LENGTH);
  localparam int CNT_W   = $clog2(CHAIN_LENGTH + 1);
  localparam int ROW_W   = $clog2(ROWS_PER_LINE);
  localparam int COL_W   = $clog2(SCAN_LINES);
  localparam int COLOR_W = 6;

  // request codes
  typedef enum logic [1:0] {
    REQ_DCLK      = 2'd0,
    REQ_LATCH_HI  = 2'd1,
    REQ_LATCH_LO  = 2'd2,
    REQ_NONE      = 2'd3
  } req_t;

  // result kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  // pulse counts with a meaning at latch fall
  localparam logic [1:0] PULSE_LATCH = 2'd1;
  localparam logic [1:0] PULSE_FRAME = 2'd2;
  localparam logic [1:0] PULSE_MAX   = 2'd3;

  // control state
  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_t;

  // memory access request
  typedef struct packed {
    logic             wr_en;
    logic [POS_W-1:0] wr_addr;
    logic [COLOR_W-1:0] wr_data;
    logic             rd_en;
    logic [POS_W-1:0] rd_addr;
  } mem_req_t;

endpackage

`default_nettype wire

>>> sv/led_driver_serial_latch_core.sv
// Serial receive and latch side of an LED panel driver. Each data clock request
// with the latch low stores six color bits into a 44-entry chain memory; with
// the latch high it counts a pulse instead. A latch fall after exactly one pulse
// with a scan address below 11 streams the 44 stored entries out as pixel-pair
// writes, one per cycle while the output is not stalled, through the single
// memory read port; input is stalled until the last one is taken. A latch fall
// after two pulses gives one frame done result. Entries never written read as
// zero; reset clears their written flags at once: no clearing pass after reset.
`default_nettype none

module led_driver_serial_latch_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  req_type,
  input  wire logic [5:0]  color_bits,
  input  wire logic [3:0]  scan_address,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             result_kind,
  output logic [5:0]       upper_row,
  output logic [6:0]       lower_row,
  output logic [6:0]       column,
  output logic [2:0]       upper_color,
  output logic [2:0]       lower_color,
  output logic             last
);

  localparam int PW = ldsl_pkg::POS_W;
  localparam int CW = ldsl_pkg::CNT_W;
  localparam int RW = ldsl_pkg::ROW_W;
  localparam int LW = ldsl_pkg::COL_W;

  ldsl_pkg::state_t state, state_next;
  ldsl_pkg::mem_req_t mreq;
  logic [ldsl_pkg::COLOR_W-1:0] rd_data;

  logic [PW-1:0] shift_position;
  logic [1:0]    pulse_count;
  logic          latch_high;
  logic [3:0]    dump_addr;

  logic [CW-1:0] iss_idx;
  logic [RW-1:0] iss_row;
  logic [LW-1:0] iss_col;
  logic          rd_pend;
  logic [RW-1:0] q_row;
  logic [LW-1:0] q_col;
  logic          q_last;

  logic accept, busy, consume, issue, iss_done;
  logic is_fall, start_dump, frame_load;
  logic [5:0] urow;

  assign is_fall    = (req_type == ldsl_pkg::REQ_LATCH_LO);
  assign accept     = in_valid && !in_stall;
  assign start_dump = accept && is_fall && (pulse_count == ldsl_pkg::PULSE_LATCH)
                      && (scan_address < 4'(ldsl_pkg::SCAN_LINES));
  assign frame_load = accept && is_fall && (pulse_count == ldsl_pkg::PULSE_FRAME);
  assign consume    = rd_pend && (!out_valid || !out_stall);
  assign iss_done   = (iss_idx == CW'(ldsl_pkg::CHAIN_LENGTH));
  assign issue      = (state == ldsl_pkg::ST_DUMP) && !iss_done && (!rd_pend || consume);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ldsl_pkg::ST_IDLE: begin
        if (start_dump) begin
          state_next = ldsl_pkg::ST_DUMP;
        end
      end
      ldsl_pkg::ST_DUMP: begin
        if (consume && q_last) begin
          state_next = ldsl_pkg::ST_IDLE;
        end
      end
      default: state_next = ldsl_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy = 1'b0;
    unique case (state)
      ldsl_pkg::ST_IDLE: busy = 1'b0;
      ldsl_pkg::ST_DUMP: busy = 1'b1;
      default:           busy = 1'b1;
    endcase
  end

  // only a latch fall needs room in the output register
  assign in_stall = busy || (out_valid && out_stall && is_fall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ldsl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // shift position, pulse counter and latch line
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_position <= '0;
      pulse_count    <= '0;
      latch_high     <= 1'b0;
    end else if (accept) begin
      case (req_type)
        ldsl_pkg::REQ_DCLK: begin
          if (latch_high) begin
            if (pulse_count != ldsl_pkg::PULSE_MAX) begin
              pulse_count <= pulse_count + 2'd1;
            end
          end else if (shift_position == PW'(ldsl_pkg::CHAIN_LENGTH - 1)) begin
            shift_position <= '0;
          end else begin
            shift_position <= shift_position + PW'(1);
          end
        end
        ldsl_pkg::REQ_LATCH_HI: begin
          latch_high  <= 1'b1;
          pulse_count <= '0;
        end
        ldsl_pkg::REQ_LATCH_LO: begin
          latch_high <= 1'b0;
          if (pulse_count == ldsl_pkg::PULSE_LATCH) begin
            shift_position <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // memory requests
  always_comb begin
    mreq.wr_en   = accept && (req_type == ldsl_pkg::REQ_DCLK) && !latch_high;
    mreq.wr_addr = shift_position;
    mreq.wr_data = color_bits;
    mreq.rd_en   = issue;
    mreq.rd_addr = iss_idx[PW-1:0];
  end

  ldsl_chain_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .req     (mreq),
    .rd_data (rd_data)
  );

  // scan address held for the dump
  always_ff @(posedge clk) begin
    if (start_dump) begin
      dump_addr <= scan_address;
    end
  end

  // read issue counters
  always_ff @(posedge clk) begin
    if (rst) begin
      iss_idx <= '0;
      iss_row <= '0;
      iss_col <= '0;
    end else if (start_dump) begin
      iss_idx <= '0;
      iss_row <= '0;
      iss_col <= '0;
    end else if (issue) begin
      iss_idx <= iss_idx + CW'(1);
      if (iss_col == LW'(ldsl_pkg::SCAN_LINES - 1)) begin
        iss_col <= '0;
        iss_row <= iss_row + RW'(1);
      end else begin
        iss_col <= iss_col + LW'(1);
      end
    end
  end

  // read data stage
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else if (issue) begin
      rd_pend <= 1'b1;
    end else if (consume) begin
      rd_pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      q_row  <= iss_row;
      q_col  <= iss_col;
      q_last <= (iss_idx == CW'(ldsl_pkg::CHAIN_LENGTH - 1));
    end
  end

  assign urow = ({2'b00, dump_addr} << 2) | {{(6-RW){1'b0}}, q_row};

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (consume || frame_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume) begin
      result_kind <= ldsl_pkg::KIND_PIXEL;
      upper_row   <= urow;
      lower_row   <= {1'b0, urow} + 7'(ldsl_pkg::HALF_ROWS);
      column      <= 7'(q_col) * 7'(ldsl_pkg::COL_STEP);
      upper_color <= rd_data[2:0];
      lower_color <= rd_data[5:3];
      last        <= q_last;
    end else if (frame_load) begin
      result_kind <= ldsl_pkg::KIND_FRAME;
      upper_row   <= '0;
      lower_row   <= '0;
      column      <= '0;
      upper_color <= '0;
      lower_color <= '0;
      last        <= 1'b1;
    end
  end

  // checks
  a_pend_in_dump: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (state == ldsl_pkg::ST_DUMP))
    else $error("read pending outside dump");

  a_no_accept_in_dump: assert property (@(posedge clk) disable iff (rst)
    (state == ldsl_pkg::ST_DUMP) |-> in_stall)
    else $error("request accepted during dump");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    iss_idx <= CW'(ldsl_pkg::CHAIN_LENGTH))
    else $error("issue index past chain length");

  a_last_ends_dump: assert property (@(posedge clk) disable iff (rst)
    (consume && q_last) |=> (state == ldsl_pkg::ST_IDLE) && !rd_pend)
    else $error("dump did not end after last entry");

  a_no_load_clash: assert property (@(posedge clk) disable iff (rst)
    !(consume && frame_load))
    else $error("pixel and frame result loaded together");

endmodule

`default_nettype wire

>>> sv/ldsl_chain_mem.sv
`default_nettype none

module ldsl_chain_mem (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire ldsl_pkg::mem_req_t          req,
  output logic [ldsl_pkg::COLOR_W-1:0]     rd_data
);

  logic [ldsl_pkg::COLOR_W-1:0] mem [ldsl_pkg::CHAIN_LENGTH];
  logic [ldsl_pkg::CHAIN_LENGTH-1:0] vld;
  logic [ldsl_pkg::COLOR_W-1:0] data_q;
  logic vld_q;

  // storage write and registered read
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      data_q <= mem[req.rd_addr];
    end
  end

  // per-entry written flags, entry reads zero until written
  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        vld_q <= vld[req.rd_addr];
      end
    end
  end

  assign rd_data = vld_q ? data_q : '0;

endmodule

`default_nettype wire
